// File: rtl/bstk_pkg.sv
// Shared types, constants and helpers for the bounded stack with search.
package bstk_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CELL_W = $clog2(DEPTH);
    localparam int CAP_W  = 7;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Search priority tree: groups of eight cells.
    localparam int GRP_W  = 3;
    localparam int GRP    = 1 << GRP_W;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
    localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W  = GRP_W + NGRP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SEARCH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_GROUP,
        S_PICK
    } t_state;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] data_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [5:0]         found_index;
        logic [6:0]         count;
        logic               is_empty;
        logic               is_full;
    } t_out_word;

    // Shift control broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

    function automatic t_data in_to_word(input logic signed [31:0] v);
        return DATA_WIDTH'(v);
    endfunction

    function automatic logic signed [31:0] word_to_out(input t_data w);
        return 32'($signed(w));
    endfunction

endpackage

// File: rtl/bounded_int_stack_with_search.sv
// Top level: bounded LIFO stack of signed words built as a shifting cell chain.
//
//  channel  | handshake               | word         | direction
//  ---------+-------------------------+--------------+----------
//  in       | i_in_valid / o_in_stall | t_in_word    | into block
//  out      | o_out_valid / i_out_stall | t_out_word | out of block
//  cfg      | i_cfg_we                | i_cfg_wdata  | into block (capacity)
//
// Push, pop, peek, clear and unknown commands: the result word is registered
// at the edge the command is accepted.
// Search registers, in order: key capture at the accept edge, then match vector
// capture, per-group priority, and group priority into the result register.
// The input is stalled after the search is taken until its result is registered.
// A new command is taken while the result word is being drained.
// Reset (i_rst_n low, synchronous) empties the stack and sets capacity 64;
// cell contents are not cleared, only entries below the count are used.
module bounded_int_stack_with_search import bstk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]  r_cap;
    t_data             r_key, n_key;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_shift            w_shift;
    t_data             w_new_word;
    t_data             w_cell_data [DEPTH];
    logic [DEPTH-1:0]  w_match;
    logic [DEPTH-1:0]  w_hits;
    logic              w_load_hits;
    logic              w_srch_hit;
    logic [CELL_W-1:0] w_srch_cell;
    logic [CMP_W-1:0]  w_cap_eff;
    logic              w_in_accept;

    // Capacity above DEPTH is used as DEPTH.
    assign w_cap_eff = (CMP_W'(r_cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(r_cap);

    assign w_new_word = in_to_word(i_in_word.data_value);

    // Cell 0 is the top of stack; cell k holds entry (count-1-k).
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_data w_up;
        t_data w_down;
        if (k == 0) begin : g_top
            assign w_up = w_new_word;
        end else begin : g_mid
            assign w_up = w_cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_bot
            assign w_down = w_cell_data[k];
        end else begin : g_nbot
            assign w_down = w_cell_data[k+1];
        end
        bstk_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .i_key       (r_key),
            .o_data      (w_cell_data[k]),
            .o_match     (w_match[k])
        );
    end

    // only cells holding live entries may hit
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_hits[k] = w_match[k] && (CNT_W'(k) < r_count);
        end
    end

    bstk_search u_search (
        .i_clk  (i_clk),
        .i_load (w_load_hits),
        .i_hits (w_hits),
        .o_hit  (w_srch_hit),
        .o_cell (w_srch_cell)
    );

    // Count and flags are reported after the command.
    function automatic t_out_word add_tail(input t_out_word w, input logic [CNT_W-1:0] cnt,
                                           input logic [CMP_W-1:0] cap);
        t_out_word r;
        r          = w;
        r.count    = 7'(cnt);
        r.is_empty = (cnt == '0);
        r.is_full  = (CMP_W'(cnt) >= cap);
        return r;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        t_out_word res;
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_shift     = '0;
        w_load_hits = 1'b0;
        res         = '0;
        res.status  = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    case (t_cmd'(i_in_word.cmd))
                        CMD_PUSH: begin
                            if (CMP_W'(r_count) >= w_cap_eff) begin
                                res.status = ST_FULL;
                            end else begin
                                w_shift.push = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (r_count == '0) begin
                                res.status = ST_EMPTY;
                            end else begin
                                res.value_out = word_to_out(w_cell_data[0]);
                                if (t_cmd'(i_in_word.cmd) == CMD_POP) begin
                                    w_shift.pop = 1'b1;
                                    n_count     = r_count - CNT_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_SEARCH: begin
                            n_key   = w_new_word;
                            n_state = S_MATCH;
                        end
                        default: begin
                        end
                    endcase
                    if (t_cmd'(i_in_word.cmd) != CMD_SEARCH) begin
                        n_out       = add_tail(res, n_count, w_cap_eff);
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_MATCH: begin
                w_load_hits = 1'b1;
                n_state     = S_GROUP;
            end
            S_GROUP: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                // output slot is free here: it was free when the search was taken
                if (w_srch_hit) begin
                    res.found_index = 6'(r_count - CNT_W'(1) - CNT_W'(w_srch_cell));
                end else begin
                    res.status = ST_NOTFOUND;
                end
                n_out       = add_tail(res, r_count, w_cap_eff);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: rtl/bstk_cell.sv
// One stack cell: holds an entry, shifts with its neighbors, compares to the key.
module bstk_cell import bstk_pkg::*; (
    input  logic   i_clk,
    input  t_shift i_shift,
    input  t_data  i_from_up,
    input  t_data  i_from_down,
    input  t_data  i_key,
    output t_data  o_data,
    output logic   o_match
);

    t_data r_data;

    // push moves entries away from the top, pop moves them toward it
    always_ff @(posedge i_clk) begin
        if (i_shift.push) begin
            r_data <= i_from_up;
        end else if (i_shift.pop) begin
            r_data <= i_from_down;
        end
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

// File: rtl/bstk_search.sv
// Registered priority tree that finds the lowest hit cell (nearest the top).
module bstk_search import bstk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [DEPTH-1:0]  i_hits,
    output logic              o_hit,
    output logic [CELL_W-1:0] o_cell
);

    logic [DEPTH-1:0]    r_hits;
    logic [NGRP*GRP-1:0] w_pad;
    logic                n_grp_hit [NGRP];
    logic [GRP_W-1:0]    n_grp_pos [NGRP];
    logic                r_grp_hit [NGRP];
    logic [GRP_W-1:0]    r_grp_pos [NGRP];
    logic [PAD_W-1:0]    w_cell;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hits <= i_hits;
        end
    end

    assign w_pad = (NGRP*GRP)'(r_hits);

    // first stage: lowest hit inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_pos[g] = '0;
            for (int p = GRP - 1; p >= 0; p--) begin
                if (w_pad[g*GRP + p]) begin
                    n_grp_hit[g] = 1'b1;
                    n_grp_pos[g] = GRP_W'(p);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp_hit[g] <= n_grp_hit[g];
            r_grp_pos[g] <= n_grp_pos[g];
        end
    end

    // second stage: lowest group with a hit
    always_comb begin
        o_hit  = 1'b0;
        w_cell = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                o_hit  = 1'b1;
                w_cell = (PAD_W'(g) << GRP_W) | PAD_W'(r_grp_pos[g]);
            end
        end
    end

    assign o_cell = CELL_W'(w_cell);

endmodule
